// ===== src/mrgq_pkg.sv =====
// package for the multi resource grant queue
// holds payload structs, state encoding, field widths and default sizes
package mrgq_pkg;

    localparam int KINDS_DEF       = 3;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_KINDS       = 4;
    localparam int GRANT_LIMIT     = 16;
    localparam int GRANT_W         = $clog2(GRANT_LIMIT + 1);
    localparam int KIND_W          = 2;
    localparam int TAG_W           = 16;
    localparam int AMOUNT_W        = 16;
    localparam int COUNT_W         = 16;

    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_DEPOSIT = 1'b1;

    localparam logic STATUS_GRANT = 1'b0;
    localparam logic STATUS_DROP  = 1'b1;

    typedef struct packed {
        logic                       func;
        logic [KIND_W-1:0]          held_kind;
        logic [TAG_W-1:0]           reply_tag;
        logic signed [AMOUNT_W-1:0] amount_0;
        logic signed [AMOUNT_W-1:0] amount_1;
        logic signed [AMOUNT_W-1:0] amount_2;
        logic signed [AMOUNT_W-1:0] amount_3;
    } in_t;

    typedef struct packed {
        logic              status;
        logic [TAG_W-1:0]  grant_tag;
        logic [KIND_W-1:0] grant_kind;
        logic              last;
    } out_t;

    // queue entry as stored in the ram
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TAG_W-1:0]  tag;
    } entry_t;

    // control from the sequencer to the count unit
    typedef struct packed {
        logic              deposit;
        logic              grant;
        logic [KIND_W-1:0] held;
    } cnt_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_FINISH
    } state_t;

endpackage

// ===== src/mrgq_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module mrgq_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/mrgq_counts.sv =====
// per-kind resource counts: saturating deposit, grant check and decrement
// depends on mrgq_pkg
module mrgq_counts
    import mrgq_pkg::*;
#(
    parameter int KINDS = KINDS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  in_t      item,
    input  cnt_ctl_t ctl,
    output logic     deposit_ok,
    output logic     grant_ok
);

    logic [COUNT_W-1:0]  count_reg  [KINDS];
    logic [COUNT_W-1:0]  count_next [KINDS];
    logic [AMOUNT_W-1:0] amt        [MAX_KINDS];
    logic [COUNT_W:0]    sum        [KINDS];

    assign amt[0] = item.amount_0;
    assign amt[1] = item.amount_1;
    assign amt[2] = item.amount_2;
    assign amt[3] = item.amount_3;

    always_comb
    begin
        deposit_ok = 1'b1;
        grant_ok   = 1'b1;
        for (int k = 0; k < KINDS; k++)
        begin
            if (amt[k][AMOUNT_W-1])
            begin
                deposit_ok = 1'b0;
            end
            // every kind but the held one needs a unit
            if (KIND_W'(k) != ctl.held && count_reg[k] == '0)
            begin
                grant_ok = 1'b0;
            end
            sum[k] = {1'b0, count_reg[k]} + {1'b0, COUNT_W'(amt[k])};
            count_next[k] = count_reg[k];
            if (ctl.deposit)
            begin
                count_next[k] = sum[k][COUNT_W] ? '1 : sum[k][COUNT_W-1:0];
            end
            else if (ctl.grant && KIND_W'(k) != ctl.held)
            begin
                count_next[k] = count_reg[k] - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KINDS; k++)
            begin
                count_reg[k] <= '0;
            end
        end
        else
        begin
            for (int k = 0; k < KINDS; k++)
            begin
                count_reg[k] <= count_next[k];
            end
        end
    end

endmodule

// ===== src/multi_resource_grant_queue.sv =====
// channel | handshake                      | payload
// input   | start high, busy low at edge   | item   (in_t)
// result  | result_strobe high, one cycle  | result (out_t)
//
// a request or deposit is taken while idle; then the queue is walked at one
// entry per cycle through the ram read port
// a dropped request or a rejected input leaves busy low
// results come out one cycle each, the final one carries last
// reset clears counts, fill and sequencer; queue contents are not cleared
// top level of the grant queue; depends on mrgq_pkg, mrgq_ram, mrgq_counts
module multi_resource_grant_queue
    import mrgq_pkg::*;
#(
    parameter int KINDS       = KINDS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  in_t  item,
    output logic result_strobe,
    output out_t result
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = AW + 1;

    state_t              state_reg, state_next;
    logic   [CW-1:0]     fill_reg, fill_next;
    logic   [CW-1:0]     kept_reg, kept_next;
    logic   [AW-1:0]     idx_reg, idx_next;
    logic   [GRANT_W-1:0] n_reg, n_next;
    entry_t              pend_reg, pend_next;
    logic                pend_valid_reg, pend_valid_next;
    out_t                result_reg, result_next;
    logic                strobe_reg, strobe_next;

    logic     accept, is_req, kind_ok, full, last_idx, take;
    logic     deposit_ok, grant_ok;
    logic     ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t   ram_wdata, rd_entry;
    cnt_ctl_t cnt_ctl;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign is_req   = (item.func == FUNC_REQUEST);
    assign kind_ok  = ({1'b0, item.held_kind} < (KIND_W + 1)'(KINDS));
    assign full     = (fill_reg == CW'(QUEUE_DEPTH));
    assign last_idx = (({1'b0, idx_reg} + 1'b1) == fill_reg);
    assign take     = (state_reg == ST_WALK) && grant_ok && (n_reg < GRANT_W'(GRANT_LIMIT));

    assign cnt_ctl.deposit = accept && !is_req && deposit_ok;
    assign cnt_ctl.grant   = take;
    assign cnt_ctl.held    = rd_entry.kind;

    mrgq_counts #(
        .KINDS(KINDS)
    ) u_counts (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .ctl       (cnt_ctl),
        .deposit_ok(deposit_ok),
        .grant_ok  (grant_ok)
    );

    mrgq_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(rd_entry)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_req)
                    begin
                        if (kind_ok && !full)
                        begin
                            state_next = ST_START;
                        end
                    end
                    else if (deposit_ok)
                    begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                state_next = (fill_reg == '0) ? ST_IDLE : ST_WALK;
            end
            ST_WALK:
            begin
                if (last_idx)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fill_next       = fill_reg;
        kept_next       = kept_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        result_next     = result_reg;
        strobe_next     = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '{kind: item.held_kind, tag: item.reply_tag};
        ram_raddr       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_req && kind_ok)
                begin
                    if (full)
                    begin
                        result_next = '{status: STATUS_DROP, grant_tag: item.reply_tag,
                                        grant_kind: item.held_kind, last: 1'b1};
                        strobe_next = 1'b1;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = fill_reg[AW-1:0];
                        fill_next = fill_reg + 1'b1;
                    end
                end
            end
            ST_START:
            begin
                idx_next        = '0;
                kept_next       = '0;
                n_next          = '0;
                pend_valid_next = 1'b0;
            end
            ST_WALK:
            begin
                ram_raddr = idx_reg + 1'b1;
                if (take)
                begin
                    // the held grant is only known not to be last once another follows
                    if (pend_valid_reg)
                    begin
                        result_next = '{status: STATUS_GRANT, grant_tag: pend_reg.tag,
                                        grant_kind: pend_reg.kind, last: 1'b0};
                        strobe_next = 1'b1;
                    end
                    pend_next       = rd_entry;
                    pend_valid_next = 1'b1;
                    n_next          = n_reg + 1'b1;
                end
                else
                begin
                    // compact in place: kept never passes the read index
                    ram_we    = 1'b1;
                    ram_waddr = kept_reg[AW-1:0];
                    ram_wdata = rd_entry;
                    kept_next = kept_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
            end
            ST_FINISH:
            begin
                fill_next = kept_reg;
                if (pend_valid_reg)
                begin
                    result_next = '{status: STATUS_GRANT, grant_tag: pend_reg.tag,
                                    grant_kind: pend_reg.kind, last: 1'b1};
                    strobe_next = 1'b1;
                end
                pend_valid_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            kept_reg       <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            kept_reg       <= kept_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.status == STATUS_DROP |-> result.last)
        else $error("drop transfer without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(QUEUE_DEPTH) && kept_reg <= fill_reg)
        else $error("queue fill out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH |=> state_reg == ST_IDLE && !pend_valid_reg)
        else $error("walk did not close");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.status == STATUS_GRANT |->
            $past(state_reg == ST_WALK || state_reg == ST_FINISH))
        else $error("grant transfer outside a walk");

endmodule
